>>> rtl/core/csfam_pkg.sv
// Shared types, constants and frame helpers for the config-set framer.
package csfam_pkg;

    // Window and queue sizing
    localparam int WINDOW_BYTES = 10;
    localparam int WIN_IDX_W    = $clog2(WINDOW_BYTES);
    localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
    localparam int PREFIX_LEN   = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int   CFG_ADDR_W      = 3;
    localparam logic REG_ACK_TIMEOUT = 1'b0;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd1000;

    // Input function codes
    localparam logic [1:0] FUNC_SEND = 2'd0;
    localparam logic [1:0] FUNC_RX   = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;

    // Result kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Frame constants
    localparam logic [7:0] SYNC_1   = 8'hB5;
    localparam logic [7:0] SYNC_2   = 8'h62;
    localparam logic [7:0] CLS_CFG  = 8'h06;
    localparam logic [7:0] ID_VALSET = 8'h8A;
    localparam logic [7:0] LAYER_RAM = 8'h01;
    localparam logic [4:0] FRAME_LEN_ONE = 5'd17;
    localparam logic [4:0] FRAME_LEN_TWO = 5'd18;
    localparam logic [4:0] CSUM_FIRST    = 5'd2;

    // Reply header bytes for an accepted and a rejected command
    localparam logic [7:0] REPLY_OK_HEAD [PREFIX_LEN] =
        '{8'hB5, 8'h62, 8'h05, 8'h01, 8'h02, 8'h00, 8'h06, 8'h8A};
    localparam logic [7:0] REPLY_NG_HEAD [PREFIX_LEN] =
        '{8'hB5, 8'h62, 8'h05, 8'h00, 8'h02, 8'h00, 8'h06, 8'h8A};

    // One unit of work for the back end: a frame to send or a status to report
    typedef struct packed {
        logic        is_status;
        logic [1:0]  status;
        logic [31:0] key;
        logic [15:0] value;
        logic        two;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_xfer;

    // Frame length for a job
    function automatic logic [4:0] frame_len(input logic two);
        return two ? FRAME_LEN_TWO : FRAME_LEN_ONE;
    endfunction

    // Frame byte at a position; checksum bytes come from the running sums
    function automatic logic [7:0] frame_byte(input t_job job, input logic [4:0] idx,
                                              input logic [7:0] ca, input logic [7:0] cb);
        logic [4:0] len;
        logic [7:0] b;
        len = frame_len(job.two);
        b   = 8'h00;
        if (idx == len - 5'd2) begin
            b = ca;
        end else if (idx == len - 5'd1) begin
            b = cb;
        end else begin
            case (idx)
                5'd0:    b = SYNC_1;
                5'd1:    b = SYNC_2;
                5'd2:    b = CLS_CFG;
                5'd3:    b = ID_VALSET;
                5'd4:    b = job.two ? 8'd10 : 8'd9;
                5'd7:    b = LAYER_RAM;
                5'd10:   b = job.key[7:0];
                5'd11:   b = job.key[15:8];
                5'd12:   b = job.key[23:16];
                5'd13:   b = job.key[31:24];
                5'd14:   b = job.value[7:0];
                5'd15:   b = job.value[15:8];
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

>>> rtl/core/config_set_framer_ack_matcher_unit.sv
// Top level of the config-set command framer with reply matcher.
//
// Input channel (i_in_valid / o_in_stall) takes one item per transfer:
// func 0 sends a config-set frame built from key, value and size flag,
// func 1 feeds one reply byte, func 2 counts one timeout tick.
// Output channel (o_out_valid / i_out_stall) gives frame bytes (kind 0,
// last on the final byte) and a status (kind 1: accepted, rejected, timeout).
// The front end accepts one item per cycle unless the queue is full, and
// updates the reply window and tick count at once; jobs pass through a
// four-entry queue to the back end, then the output register. A frame
// has 17 or 18 bytes, sent one byte per cycle unless the receiver stalls,
// by the back-end serializer. The input stalls only while the queue is full.
// When the receiver stalls, the output register holds its transfer and the
// queue absorbs new jobs until it fills.
// Reset (synchronous, active low) empties the queue and output register,
// returns the matcher to idle and sets ack_timeout_ticks to 1000.
// ack_timeout_ticks lies at byte address 0 of the APB port.
module config_set_framer_ack_matcher_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_func,
    input  logic [31:0]                      i_cfg_key,
    input  logic [15:0]                      i_cfg_value,
    input  logic                             i_two_byte_value,
    input  logic [7:0]                       i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_kind,
    output logic [7:0]                       o_tx_byte,
    output logic [1:0]                       o_status,
    output logic                             o_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [csfam_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import csfam_pkg::*;

    logic [15:0] r_timeout;
    logic        full;
    logic        accept;
    logic        pop;
    t_job_xfer   push;
    t_job_xfer   head;

    assign accept     = i_in_valid && !full;
    assign o_in_stall = full;

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= ACK_TIMEOUT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ACK_TIMEOUT) begin
            r_timeout <= pwdata[15:0];
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            REG_ACK_TIMEOUT: prdata = {16'h0000, r_timeout};
            default:         prdata = 32'h0000_0000;
        endcase
    end

    assign pready = 1'b1;

    csfam_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_func           (i_func),
        .i_cfg_key        (i_cfg_key),
        .i_cfg_value      (i_cfg_value),
        .i_two_byte_value (i_two_byte_value),
        .i_rx_byte        (i_rx_byte),
        .i_timeout        (r_timeout),
        .o_push           (push)
    );

    csfam_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    csfam_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule

>>> rtl/core/csfam_front.sv
// Front end: accepts items, tracks the reply window and timeout, queues jobs.
module csfam_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_func,
    input  logic [31:0]           i_cfg_key,
    input  logic [15:0]           i_cfg_value,
    input  logic                  i_two_byte_value,
    input  logic [7:0]            i_rx_byte,
    input  logic [15:0]           i_timeout,
    output csfam_pkg::t_job_xfer  o_push
);
    import csfam_pkg::*;

    logic [7:0]        r_window [WINDOW_BYTES];
    logic [7:0]        n_window [WINDOW_BYTES];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_await, n_await;
    logic [15:0]       r_elapsed, n_elapsed;
    logic              ack_hit, nak_hit;
    t_job_xfer         push;

    // Place the new byte in the window; once it is full, shift out the oldest byte
    always_comb begin
        n_window = r_window;
        if (r_fill < FILL_W'(WINDOW_BYTES)) begin
            n_window[r_fill[WIN_IDX_W-1:0]] = i_rx_byte;
        end else begin
            for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
                n_window[i] = r_window[i + 1];
            end
            n_window[WINDOW_BYTES-1] = i_rx_byte;
        end
    end

    // Compare the window head against the reply headers
    always_comb begin
        ack_hit = 1'b1;
        nak_hit = 1'b1;
        for (int i = 0; i < PREFIX_LEN; i++) begin
            if (n_window[i] != REPLY_OK_HEAD[i]) ack_hit = 1'b0;
            if (n_window[i] != REPLY_NG_HEAD[i]) nak_hit = 1'b0;
        end
    end

    // Classify the item and update the transaction state
    always_comb begin
        n_fill          = r_fill;
        n_await         = r_await;
        n_elapsed       = r_elapsed;
        push            = '0;
        push.job.key    = i_cfg_key;
        push.job.value  = i_cfg_value;
        push.job.two    = i_two_byte_value;
        if (i_accept) begin
            case (i_func)
                FUNC_SEND: begin
                    push.valid = 1'b1;
                    n_fill     = '0;
                    n_elapsed  = '0;
                    n_await    = 1'b1;
                end
                FUNC_RX: begin
                    if (r_await) begin
                        if (r_fill < FILL_W'(WINDOW_BYTES)) begin
                            n_fill = r_fill + 1'b1;
                        end
                        if (n_fill == FILL_W'(WINDOW_BYTES) && (ack_hit || nak_hit)) begin
                            n_await            = 1'b0;
                            push.valid         = 1'b1;
                            push.job.is_status = 1'b1;
                            push.job.status    = ack_hit ? ST_ACCEPTED : ST_REJECTED;
                        end
                    end
                end
                FUNC_TICK: begin
                    if (r_await) begin
                        if (r_elapsed != 16'hFFFF) begin
                            n_elapsed = r_elapsed + 16'd1;
                        end
                        if (n_elapsed >= i_timeout) begin
                            n_await            = 1'b0;
                            push.valid         = 1'b1;
                            push.job.is_status = 1'b1;
                            push.job.status    = ST_TIMEOUT;
                        end
                    end
                end
                default: begin
                    push.valid = 1'b0;
                end
            endcase
        end
    end

    // Hold the window bytes; they matter only below the fill count
    always_ff @(posedge i_clk) begin
        if (i_accept && i_func == FUNC_RX && r_await) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_await   <= 1'b0;
            r_elapsed <= '0;
        end else begin
            r_fill    <= n_fill;
            r_await   <= n_await;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_push = push;

endmodule

>>> rtl/core/csfam_queue.sv
// Short job queue between the front and back ends.
module csfam_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csfam_pkg::t_job_xfer  i_push,
    input  logic                  i_pop,
    output logic                  o_full,
    output csfam_pkg::t_job_xfer  o_head
);
    import csfam_pkg::*;

    t_job                   r_slot [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   do_pop;

    assign do_pop = i_pop && (r_cnt != '0);

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr] <= i_push.job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push.valid && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push.valid && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full       = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_slot[r_rd];

endmodule

>>> rtl/core/csfam_back.sv
// Back end: serializes frames byte by byte and reports status into the output register.
module csfam_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  csfam_pkg::t_job_xfer  i_head,
    output logic                  o_pop,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic                  o_kind,
    output logic [7:0]            o_tx_byte,
    output logic [1:0]            o_status,
    output logic                  o_last
);
    import csfam_pkg::*;

    logic       r_valid, n_valid;
    logic       r_kind;
    logic [7:0] r_tx;
    logic [1:0] r_status;
    logic       r_last;
    logic [4:0] r_idx, n_idx;
    logic [7:0] r_ca, n_ca, r_cb, n_cb;
    logic       load;
    logic       at_last_byte;
    logic [7:0] cur_byte;
    logic [4:0] len;

    assign load         = i_head.valid && (!r_valid || !i_out_stall);
    assign len          = frame_len(i_head.job.two);
    assign at_last_byte = (r_idx == len - 5'd1);
    assign cur_byte     = frame_byte(i_head.job, r_idx, r_ca, r_cb);
    assign o_pop        = load && (i_head.job.is_status || at_last_byte);

    // Step the byte index and running checksum
    always_comb begin
        n_idx   = r_idx;
        n_ca    = r_ca;
        n_cb    = r_cb;
        n_valid = i_out_stall ? r_valid : 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (!i_head.job.is_status) begin
                n_idx = at_last_byte ? 5'd0 : r_idx + 5'd1;
                if (r_idx == 5'd0) begin
                    n_ca = 8'h00;
                    n_cb = 8'h00;
                end else if (r_idx >= CSUM_FIRST && r_idx < len - 5'd2) begin
                    n_ca = r_ca + cur_byte;
                    n_cb = r_cb + n_ca;
                end
            end
        end
    end

    // Load the output payload on each transfer slot
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_head.job.is_status) begin
                r_kind   <= KIND_STATUS;
                r_tx     <= 8'h00;
                r_status <= i_head.job.status;
                r_last   <= 1'b1;
            end else begin
                r_kind   <= KIND_TX;
                r_tx     <= cur_byte;
                r_status <= ST_ACCEPTED;
                r_last   <= at_last_byte;
            end
        end
        r_ca <= n_ca;
        r_cb <= n_cb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

>>> tb/tb.sv
// Testbench for config_set_framer_ack_matcher_unit: directed and random traffic with a scoreboard.
`timescale 1ns / 100ps

module tb;
    import csfam_pkg::*;

    // Frame header bytes and reply prefixes, written out from the frame format
    localparam logic [7:0]  FR_SYNC_A = 8'hB5;
    localparam logic [7:0]  FR_SYNC_B = 8'h62;
    localparam logic [7:0]  FR_CLASS  = 8'h06;
    localparam logic [7:0]  FR_ID     = 8'h8A;
    localparam logic [7:0]  FR_LAYER  = 8'h01;
    localparam logic [63:0] ACK_WORD  = 64'hB562_0501_0200_068A;
    localparam logic [63:0] NAK_WORD  = 64'hB562_0500_0200_068A;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [1:0]  STATUS_NONE = 2'd0;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_func;
    logic [31:0]           i_cfg_key;
    logic [15:0]           i_cfg_value;
    logic                  i_two_byte_value;
    logic [7:0]            i_rx_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_kind;
    logic [7:0]            o_tx_byte;
    logic [1:0]            o_status;
    logic                  o_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Matcher copy: reply window, fill, waiting flag, tick count, register
    logic [7:0]  reply_win [WINDOW_BYTES];
    int          win_fill;
    bit          reply_pending;
    logic [15:0] ticks_seen;
    logic [15:0] timeout_ticks;

    t_result frames_and_status_q [$];
    int      mismatch_count;
    int      working_items;
    int      send_idle_pct;
    int      out_stall_pct;
    int      hold_cycles;

    config_set_framer_ack_matcher_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_cfg_key        (i_cfg_key),
        .i_cfg_value      (i_cfg_value),
        .i_two_byte_value (i_two_byte_value),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_tx_byte        (o_tx_byte),
        .o_status         (o_status),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #1 i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void expect_result(input logic kind, input logic [7:0] tx,
                                          input logic [1:0] st, input logic lst);
        t_result r;
        r.kind    = kind;
        r.tx_byte = tx;
        r.status  = st;
        r.last    = lst;
        frames_and_status_q.push_back(r);
    endfunction

    function automatic logic [7:0] reply_byte(input bit nak, input int idx);
        logic [63:0] word;
        word = nak ? NAK_WORD : ACK_WORD;
        return word[63 - 8 * idx -: 8];
    endfunction

    // Advance the matcher copy by one item; return 1 if the item did any work
    function automatic bit framer_matcher_step(input logic [1:0] func, input logic [31:0] key,
                                               input logic [15:0] value, input logic two,
                                               input logic [7:0] rx);
        logic [7:0] fr [18];
        logic [7:0] ca;
        logic [7:0] cb;
        int         n;
        int         i;
        bit         is_ack;
        bit         is_nak;
        framer_matcher_step = 1'b0;
        case (func)
            FUNC_SEND: begin
                n = two ? 18 : 17;
                for (i = 0; i < 18; i++) fr[i] = 8'h00;
                fr[0]  = FR_SYNC_A;
                fr[1]  = FR_SYNC_B;
                fr[2]  = FR_CLASS;
                fr[3]  = FR_ID;
                fr[4]  = two ? 8'd10 : 8'd9;
                fr[7]  = FR_LAYER;
                fr[10] = key[7:0];
                fr[11] = key[15:8];
                fr[12] = key[23:16];
                fr[13] = key[31:24];
                fr[14] = value[7:0];
                fr[15] = value[15:8];
                // Fletcher sums from the class byte through the last value byte
                ca = 8'h00;
                cb = 8'h00;
                for (i = 2; i < n - 2; i++) begin
                    ca = ca + fr[i];
                    cb = cb + ca;
                end
                fr[n - 2] = ca;
                fr[n - 1] = cb;
                for (i = 0; i < n; i++) expect_result(KIND_TX, fr[i], STATUS_NONE, i == n - 1);
                for (i = 0; i < WINDOW_BYTES; i++) reply_win[i] = 8'h00;
                win_fill      = 0;
                ticks_seen    = 16'd0;
                reply_pending = 1'b1;
                framer_matcher_step = 1'b1;
            end
            FUNC_RX: begin
                if (reply_pending) begin
                    framer_matcher_step = 1'b1;
                    // Fill the window, then drop the oldest byte for each new one
                    if (win_fill < WINDOW_BYTES) begin
                        reply_win[win_fill] = rx;
                        win_fill++;
                    end else begin
                        for (i = 0; i < WINDOW_BYTES - 1; i++) reply_win[i] = reply_win[i + 1];
                        reply_win[WINDOW_BYTES - 1] = rx;
                    end
                    if (win_fill == WINDOW_BYTES) begin
                        is_ack = 1'b1;
                        is_nak = 1'b1;
                        for (i = 0; i < PREFIX_LEN; i++) begin
                            if (reply_win[i] != reply_byte(1'b0, i)) is_ack = 1'b0;
                            if (reply_win[i] != reply_byte(1'b1, i)) is_nak = 1'b0;
                        end
                        if (is_ack) begin
                            reply_pending = 1'b0;
                            expect_result(KIND_STATUS, 8'h00, ST_ACCEPTED, 1'b1);
                        end else if (is_nak) begin
                            reply_pending = 1'b0;
                            expect_result(KIND_STATUS, 8'h00, ST_REJECTED, 1'b1);
                        end
                    end
                end
            end
            FUNC_TICK: begin
                if (reply_pending) begin
                    framer_matcher_step = 1'b1;
                    if (ticks_seen != 16'hFFFF) ticks_seen++;
                    if (ticks_seen >= timeout_ticks) begin
                        reply_pending = 1'b0;
                        expect_result(KIND_STATUS, 8'h00, ST_TIMEOUT, 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Offer one item, hold it until the transfer, then update the matcher copy
    task automatic send_item(input logic [1:0] func, input logic [31:0] key,
                             input logic [15:0] value, input logic two, input logic [7:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_func           = func;
        i_cfg_key        = key;
        i_cfg_value      = value;
        i_two_byte_value = two;
        i_rx_byte        = rx;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        if (framer_matcher_step(func, key, value, two, rx)) working_items++;
        @(negedge i_clk);
    endtask

    task automatic send_command(input logic [31:0] key, input logic [15:0] value, input logic two);
        send_item(FUNC_SEND, key, value, two, 8'($urandom_range(255)));
    endtask

    task automatic send_rx(input logic [7:0] b);
        send_item(FUNC_RX, $urandom, 16'($urandom_range(65535)), 1'($urandom_range(1)), b);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, $urandom, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
    endtask

    // Send the first n bytes of an ACK or NAK reply, optionally with one byte spoiled
    task automatic send_reply(input bit nak, input int bad_pos, input int n_bytes,
                              input int tick_pct);
        logic [7:0] b;
        logic [7:0] flip;
        int         k;
        for (k = 0; k < n_bytes; k++) begin
            b = (k < PREFIX_LEN) ? reply_byte(nak, k) : 8'($urandom_range(255));
            if (k == bad_pos) begin
                flip = 8'($urandom_range(1, 255));
                b    = b ^ flip;
            end
            if ($urandom_range(99) < tick_pct) send_tick();
            send_rx(b);
        end
    endtask

    // Tick until the pending transaction times out
    task automatic tick_out();
        while (reply_pending) send_tick();
    endtask

    // Pause the sender until every expected result has come, then let the block settle
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (frames_and_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One APB access to the timeout register; a read checks the returned value
    task automatic cfg_access(input bit write, input logic [15:0] value);
        logic [31:0] upper;
        upper   = $urandom;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {REG_ACK_TIMEOUT, 2'b00};
        pwdata  = {upper[31:16], value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (write) begin
            timeout_ticks = value;
        end else if (prdata[15:0] !== timeout_ticks) begin
            flag_mismatch("ack_timeout_ticks readback", int'(prdata[15:0]),
                          int'(timeout_ticks));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_timeout(input logic [15:0] value);
        wait_drain();
        cfg_access(1'b1, value);
        cfg_access(1'b0, 16'd0);
    endtask

    // Reset value of the register; ticks well below it leave the wait running
    task automatic test_default_timeout();
        cfg_access(1'b0, 16'd0);
        send_command(32'h1234_5678, 16'h00AB, 1'b0);
        repeat (20) send_tick();
        send_reply(1'b0, -1, 10, 0);
    endtask

    // Field extremes in the frame, both sizes, each answered by a reply
    task automatic test_frame_fields();
        send_command(32'h0000_0000, 16'h0000, 1'b0);
        send_reply(1'b0, -1, 10, 0);
        send_command(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_reply(1'b1, -1, 10, 0);
        send_command(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        send_reply(1'b0, -1, 10, 0);
        send_command(32'hA5C3_3C5A, 16'h8001, 1'b1);
        send_reply(1'b0, -1, 10, 0);
    endtask

    // Ignored items, window slide, abandon on a new command, spoiled prefix
    task automatic test_reply_matching();
        set_timeout(16'd3);
        send_rx(reply_byte(1'b0, 0));
        send_tick();
        send_item(FUNC_UNUSED, $urandom, 16'($urandom_range(65535)), 1'b1,
                  8'($urandom_range(255)));
        send_command($urandom, 16'($urandom_range(65535)), 1'b1);
        repeat (3) send_rx(8'($urandom_range(255)));
        send_reply(1'b0, -1, 10, 0);
        send_command($urandom, 16'($urandom_range(65535)), 1'b0);
        send_reply(1'b0, -1, 5, 0);
        send_command($urandom, 16'($urandom_range(65535)), 1'b1);
        send_reply(1'b1, -1, 10, 0);
        send_command($urandom, 16'($urandom_range(65535)), 1'b0);
        send_item(FUNC_UNUSED, $urandom, 16'($urandom_range(65535)), 1'b0,
                  8'($urandom_range(255)));
        send_reply(1'b0, 2, 10, 0);
        tick_out();
    endtask

    // Zero, one, two and full-scale timeout settings
    task automatic test_timeout_limits();
        set_timeout(16'd0);
        send_command($urandom, 16'($urandom_range(65535)), 1'b0);
        send_tick();
        set_timeout(16'd1);
        send_command($urandom, 16'($urandom_range(65535)), 1'b1);
        send_tick();
        set_timeout(16'd2);
        send_command($urandom, 16'($urandom_range(65535)), 1'b0);
        send_tick();
        send_command($urandom, 16'($urandom_range(65535)), 1'b1);
        tick_out();
        set_timeout(16'hFFFF);
        send_command($urandom, 16'($urandom_range(65535)), 1'b0);
        repeat (20) send_tick();
        send_reply(1'b1, -1, 10, 0);
    endtask

    // Hold the receiver off while commands keep coming, then drain completely
    task automatic test_backpressure();
        send_idle_pct = 0;
        out_stall_pct = 0;
        @(posedge i_clk);
        hold_cycles = 400;
        @(negedge i_clk);
        repeat (8) send_command($urandom, 16'($urandom_range(65535)), 1'($urandom_range(1)));
        send_reply(1'b1, -1, 10, 0);
        wait_drain();
        send_command($urandom, 16'($urandom_range(65535)), 1'($urandom_range(1)));
        send_reply(1'b0, -1, 10, 0);
    endtask

    // Mostly well-formed exchanges, some spoiled replies, some noise
    task automatic random_exchange();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            send_command($urandom, 16'($urandom_range(65535)), 1'($urandom_range(1)));
            case ($urandom_range(5))
                0, 1: send_reply(1'b0, -1, 10, 10);
                2:    send_reply(1'b1, -1, 10, 10);
                3: begin
                    repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(255)));
                    send_reply(1'($urandom_range(1)), -1, 10, 10);
                end
                4:       tick_out();
                default: send_reply(1'($urandom_range(1)), -1, $urandom_range(1, 9), 10);
            endcase
        end else if (pick < 85) begin
            send_command($urandom, 16'($urandom_range(65535)), 1'($urandom_range(1)));
            send_reply(1'($urandom_range(1)), $urandom_range(PREFIX_LEN - 1), 10, 10);
            repeat ($urandom_range(3)) send_tick();
        end else begin
            repeat ($urandom_range(1, 3))
                send_item(2'($urandom_range(3)), $urandom, 16'($urandom_range(65535)),
                          1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random_phase(input int n, input int send_pct, input int stall_pct);
        int start;
        set_timeout(16'($urandom_range(1, 40)));
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
        start = working_items;
        while (working_items - start < n) random_exchange();
    endtask

    task automatic test_random_traffic();
        run_random_phase(75, 0, 0);
        run_random_phase(75, 83, 0);
        run_random_phase(75, 0, 83);
        run_random_phase(75, 35, 35);
    endtask

    // Drive the receiver stall: a counted hold-off first, else random
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall = 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall = ($urandom_range(99) < out_stall_pct);
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin : check_output
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frames_and_status_q.size() == 0) begin
                flag_mismatch("output with nothing pending", int'(o_tx_byte), -1);
            end else begin
                want = frames_and_status_q.pop_front();
                if (o_kind !== want.kind)
                    flag_mismatch("kind", int'(o_kind), int'(want.kind));
                if (o_tx_byte !== want.tx_byte)
                    flag_mismatch("tx_byte", int'(o_tx_byte), int'(want.tx_byte));
                if (o_status !== want.status)
                    flag_mismatch("status", int'(o_status), int'(want.status));
                if (o_last !== want.last)
                    flag_mismatch("last", int'(o_last), int'(want.last));
            end
        end
    end

    // End the run if no transfer happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transfer in %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_func           = FUNC_SEND;
        i_cfg_key        = 32'd0;
        i_cfg_value      = 16'd0;
        i_two_byte_value = 1'b0;
        i_rx_byte        = 8'd0;
        i_out_stall      = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = 32'd0;
        foreach (reply_win[i]) reply_win[i] = 8'h00;
        win_fill         = 0;
        reply_pending    = 1'b0;
        ticks_seen       = 16'd0;
        timeout_ticks    = 16'd1000;
        mismatch_count   = 0;
        working_items    = 0;
        send_idle_pct    = 0;
        out_stall_pct    = 0;
        hold_cycles      = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_default_timeout();
        test_frame_fields();
        test_reply_matching();
        test_timeout_limits();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/csfam_pkg.sv
rtl/core/csfam_front.sv
rtl/core/csfam_queue.sv
rtl/core/csfam_back.sv
rtl/core/config_set_framer_ack_matcher_unit.sv
tb/tb.sv
